// ===== rtl/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types, codes and sizes for the prime sieve table: the control word
// of the microcode, the step names, the jump conditions and the status codes.
// ----------------------------------------------------------------------------
package pst_pkg;

   localparam int MAX_LIMIT_DEFAULT  = 1024;
   localparam int LIST_DEPTH_DEFAULT = 256;

   localparam int VALUE_W = 11;
   localparam int ORDER_W = 8;
   localparam int COUNT_W = 9;
   localparam int STATUS_W = 2;
   localparam int COUNT_MAX = 511;

   localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 11'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SIEVE = 2'd2;

   localparam logic CMD_SIEVE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [3:0] {
      STEP_IDLE      = 4'd0,
      STEP_DISPATCH  = 4'd1,
      STEP_CLEAR     = 4'd2,
      STEP_OUTER     = 4'd3,
      STEP_TEST      = 4'd4,
      STEP_MARK      = 4'd5,
      STEP_NEXT_I    = 4'd6,
      STEP_COL_START = 4'd7,
      STEP_COL_CHECK = 4'd8,
      STEP_COL_STORE = 4'd9,
      STEP_SIEVE_RET = 4'd10,
      STEP_QUERY     = 4'd11,
      STEP_QUERY_RET = 4'd12
   } step_type;

   typedef enum logic [3:0] {
      COND_SEQ      = 4'd0,
      COND_JUMP     = 4'd1,
      COND_HOLD_REQ = 4'd2,
      COND_HOLD_RSP = 4'd3,
      COND_QUERY    = 4'd4,
      COND_SQ_GT_N  = 4'd5,
      COND_MAP_SET  = 4'd6,
      COND_JN_LE_N  = 4'd7,
      COND_J_LT_N   = 4'd8,
      COND_I_GT_N   = 4'd9
   } cond_type;

   typedef enum logic [1:0] {
      I_HOLD = 2'd0,
      I_SET2 = 2'd1,
      I_INC  = 2'd2
   } op_i_type;

   typedef enum logic [2:0] {
      J_HOLD   = 3'd0,
      J_ZERO   = 3'd1,
      J_INC    = 3'd2,
      J_SQUARE = 3'd3,
      J_ADD_I  = 3'd4
   } op_j_type;

   typedef enum logic {
      RSP_COUNT = 1'b0,
      RSP_QUERY = 1'b1
   } rsp_src_type;

   typedef struct packed {
      logic        load_req;
      op_i_type    op_i;
      op_j_type    op_j;
      logic        clr_cnt;
      logic        map_we;
      logic        map_wd;
      logic        map_rd;
      logic        store;
      logic        list_rd;
      logic        emit;
      rsp_src_type rsp_src;
      cond_type    cond;
      step_type    target;
   } ctrl_type;

   typedef struct packed {
      logic is_query;
      logic sq_gt_n;
      logic map_set;
      logic jn_le_n;
      logic j_lt_n;
      logic i_gt_n;
      logic rsp_busy;
   } flags_type;

   localparam ctrl_type CTRL_NOP = '{
      load_req: 1'b0,
      op_i:     I_HOLD,
      op_j:     J_HOLD,
      clr_cnt:  1'b0,
      map_we:   1'b0,
      map_wd:   1'b0,
      map_rd:   1'b0,
      store:    1'b0,
      list_rd:  1'b0,
      emit:     1'b0,
      rsp_src:  RSP_COUNT,
      cond:     COND_SEQ,
      target:   STEP_IDLE
   };

endpackage

// ===== rtl/pst_rom.sv =====
// ----------------------------------------------------------------------------
// pst_rom
// Control store: one control word for each step of the sieve and query
// program.
// ----------------------------------------------------------------------------
module pst_rom
   import pst_pkg::*;
(
   input  step_type step,
   output ctrl_type ctrl
);

   always_comb begin
      ctrl = CTRL_NOP;
      case (step)
         STEP_IDLE: begin
            ctrl.load_req = 1'b1;
            ctrl.op_j     = J_ZERO;
            ctrl.cond     = COND_HOLD_REQ;
         end
         STEP_DISPATCH: begin
            ctrl.op_i    = I_SET2;
            ctrl.clr_cnt = 1'b1;
            ctrl.cond    = COND_QUERY;
            ctrl.target  = STEP_QUERY;
         end
         STEP_CLEAR: begin
            ctrl.map_we = 1'b1;
            ctrl.map_wd = 1'b0;
            ctrl.op_j   = J_INC;
            ctrl.cond   = COND_J_LT_N;
            ctrl.target = STEP_CLEAR;
         end
         STEP_OUTER: begin
            ctrl.map_rd = 1'b1;
            ctrl.cond   = COND_SQ_GT_N;
            ctrl.target = STEP_COL_START;
         end
         STEP_TEST: begin
            ctrl.op_j   = J_SQUARE;
            ctrl.cond   = COND_MAP_SET;
            ctrl.target = STEP_NEXT_I;
         end
         STEP_MARK: begin
            ctrl.map_we = 1'b1;
            ctrl.map_wd = 1'b1;
            ctrl.op_j   = J_ADD_I;
            ctrl.cond   = COND_JN_LE_N;
            ctrl.target = STEP_MARK;
         end
         STEP_NEXT_I: begin
            ctrl.op_i   = I_INC;
            ctrl.cond   = COND_JUMP;
            ctrl.target = STEP_OUTER;
         end
         STEP_COL_START: begin
            ctrl.op_i = I_SET2;
         end
         STEP_COL_CHECK: begin
            ctrl.map_rd = 1'b1;
            ctrl.cond   = COND_I_GT_N;
            ctrl.target = STEP_SIEVE_RET;
         end
         STEP_COL_STORE: begin
            ctrl.store  = 1'b1;
            ctrl.op_i   = I_INC;
            ctrl.cond   = COND_JUMP;
            ctrl.target = STEP_COL_CHECK;
         end
         STEP_SIEVE_RET: begin
            ctrl.emit    = 1'b1;
            ctrl.rsp_src = RSP_COUNT;
            ctrl.cond    = COND_HOLD_RSP;
            ctrl.target  = STEP_IDLE;
         end
         STEP_QUERY: begin
            ctrl.list_rd = 1'b1;
         end
         STEP_QUERY_RET: begin
            ctrl.emit    = 1'b1;
            ctrl.rsp_src = RSP_QUERY;
            ctrl.cond    = COND_HOLD_RSP;
            ctrl.target  = STEP_IDLE;
         end
         default: begin
            ctrl.cond   = COND_JUMP;
            ctrl.target = STEP_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/pst_seq.sv =====
// ----------------------------------------------------------------------------
// pst_seq
// Step counter: advances, holds or jumps on the condition that the current
// control word selects.
// ----------------------------------------------------------------------------
module pst_seq
   import pst_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  ctrl_type  ctrl,
   input  flags_type flags,
   output step_type  step
);

   step_type step_ff;
   step_type step_in;
   step_type step_inc;
   logic     taken;

   assign step_inc = step_type'(4'(step_ff + 1));

   always_comb begin
      taken = 1'b0;
      case (ctrl.cond)
         COND_QUERY:   taken = flags.is_query;
         COND_SQ_GT_N: taken = flags.sq_gt_n;
         COND_MAP_SET: taken = flags.map_set;
         COND_JN_LE_N: taken = flags.jn_le_n;
         COND_J_LT_N:  taken = flags.j_lt_n;
         COND_I_GT_N:  taken = flags.i_gt_n;
         default:      taken = 1'b0;
      endcase
   end

   always_comb begin
      case (ctrl.cond)
         COND_SEQ:      step_in = step_inc;
         COND_JUMP:     step_in = ctrl.target;
         COND_HOLD_REQ: step_in = req_valid ? step_inc : step_ff;
         COND_HOLD_RSP: step_in = flags.rsp_busy ? step_ff : ctrl.target;
         default:       step_in = taken ? ctrl.target : step_inc;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign step = step_ff;

endmodule

// ===== rtl/pst_datapath.sv =====
// ----------------------------------------------------------------------------
// pst_datapath
// Sieve datapath: limit register, index and multiple registers, count, the
// composite bitmap, the prime list and the result register.
// ----------------------------------------------------------------------------
module pst_datapath
   import pst_pkg::*;
#(
   parameter int MAX_LIMIT  = MAX_LIMIT_DEFAULT,
   parameter int LIST_DEPTH = LIST_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_type            ctrl,
   output flags_type           flags,
   input  logic                csr_write,
   input  logic [VALUE_W-1:0]  csr_max_value,
   input  logic                req_valid,
   input  logic                req_cmd,
   input  logic [ORDER_W-1:0]  req_order,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VALUE_W-1:0]  rsp_value,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int NW  = $clog2(MAX_LIMIT + 1);
   localparam int IW  = NW + 1;
   localparam int JW  = NW + 1;
   localparam int SQW = 2 * IW;
   localparam int LW  = $clog2(LIST_DEPTH);
   localparam int CAP = (LIST_DEPTH < COUNT_MAX) ? LIST_DEPTH : COUNT_MAX;

   logic [VALUE_W-1:0]  max_value_reg_ff;
   logic                cmd_ff;
   logic [ORDER_W-1:0]  order_ff;
   logic [NW-1:0]       n_ff,       n_in;
   logic [IW-1:0]       i_ff,       i_in;
   logic [JW-1:0]       j_ff,       j_in;
   logic [COUNT_W-1:0]  cnt_ff,     cnt_in;
   logic [COUNT_W-1:0]  count_ff;
   logic                done_ff;
   logic                map_rd_ff;
   logic [VALUE_W-1:0]  list_rd_ff;
   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                map_mem [MAX_LIMIT+1];
   logic [VALUE_W-1:0]  list_mem [LIST_DEPTH];

   logic                accept;
   logic                rsp_busy;
   logic                rsp_load;
   logic                list_we;
   logic [SQW-1:0]      sq;
   logic [JW-1:0]       jn;
   logic [31:0]         limit;
   logic [LW-1:0]       list_raddr;

   assign accept   = ctrl.load_req && req_valid;
   assign rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_load = ctrl.emit && !rsp_busy;
   assign sq       = SQW'(i_ff) * SQW'(i_ff);
   assign jn       = j_ff + JW'(i_ff);
   assign limit    = (32'(max_value_reg_ff) > MAX_LIMIT) ? MAX_LIMIT
                                                         : 32'(max_value_reg_ff);
   assign list_we  = ctrl.store && !map_rd_ff && (32'(cnt_ff) < CAP);
   assign list_raddr = LW'(32'(order_ff) - 32'd1);

   assign flags.is_query = (cmd_ff == CMD_QUERY);
   assign flags.sq_gt_n  = sq > SQW'(n_ff);
   assign flags.map_set  = map_rd_ff;
   assign flags.jn_le_n  = jn <= JW'(n_ff);
   assign flags.j_lt_n   = j_ff < JW'(n_ff);
   assign flags.i_gt_n   = i_ff > IW'(n_ff);
   assign flags.rsp_busy = rsp_busy;

   always_comb begin
      n_in = accept ? NW'(limit) : n_ff;

      case (ctrl.op_i)
         I_SET2:  i_in = IW'(2);
         I_INC:   i_in = i_ff + IW'(1);
         default: i_in = i_ff;
      endcase

      case (ctrl.op_j)
         J_ZERO:   j_in = '0;
         J_INC:    j_in = j_ff + JW'(1);
         J_SQUARE: j_in = JW'(sq);
         J_ADD_I:  j_in = jn;
         default:  j_in = j_ff;
      endcase

      if (ctrl.clr_cnt) begin
         cnt_in = '0;
      end else if (list_we) begin
         cnt_in = cnt_ff + COUNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end

      if (ctrl.rsp_src == RSP_COUNT) begin
         rsp_value_in  = VALUE_W'(cnt_ff);
         rsp_status_in = ST_OK;
      end else if (!done_ff) begin
         rsp_value_in  = '0;
         rsp_status_in = ST_NO_SIEVE;
      end else if (order_ff == '0 || 32'(order_ff) > 32'(count_ff)
                   || 32'(order_ff) > LIST_DEPTH) begin
         rsp_value_in  = '0;
         rsp_status_in = ST_RANGE;
      end else begin
         rsp_value_in  = list_rd_ff;
         rsp_status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_value_reg_ff <= MAX_VALUE_RESET;
         count_ff         <= '0;
         done_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         cnt_ff           <= '0;
      end else begin
         if (csr_write) begin
            max_value_reg_ff <= csr_max_value;
         end
         if (rsp_load && ctrl.rsp_src == RSP_COUNT) begin
            count_ff <= cnt_ff;
            done_ff  <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         order_ff <= req_order;
      end
      n_ff   <= n_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      if (rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.map_we) begin
         map_mem[j_ff[NW-1:0]] <= ctrl.map_wd;
      end
      if (ctrl.map_rd) begin
         map_rd_ff <= map_mem[i_ff[NW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[LW'(cnt_ff)] <= VALUE_W'(i_ff);
      end
      if (ctrl.list_rd) begin
         list_rd_ff <= list_mem[list_raddr];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   a_map_in_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.map_we |-> j_ff <= JW'(n_ff))
      else $error("bitmap write beyond the sieve limit");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= CAP)
      else $error("prime count beyond list capacity");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !done_ff)
      else $error("result or sieve flag survived reset");

endmodule

// ===== rtl/prime_sieve_table.sv =====
// ----------------------------------------------------------------------------
// prime_sieve_table
// Sieve of Eratosthenes with a prime list, run by a microcoded sequencer.
// Sieve item: clear the bitmap, mark multiples of each prime up to sqrt(n),
// list the primes and return their count. Query item: return the listed prime.
// One item at a time: a new request waits until the last result is registered.
// Reset: no sieve, count zero, max_value 2; the memories are not cleared.
// ----------------------------------------------------------------------------
module prime_sieve_table
   import pst_pkg::*;
#(
   parameter int MAX_LIMIT  = MAX_LIMIT_DEFAULT,
   parameter int LIST_DEPTH = LIST_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_cmd,
   input  logic [ORDER_W-1:0]  req_order,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VALUE_W-1:0]  rsp_value,
   output logic [STATUS_W-1:0] rsp_status,
   input  logic                csr_write,
   input  logic [VALUE_W-1:0]  csr_max_value
);

   step_type  step;
   ctrl_type  ctrl;
   flags_type flags;

   assign req_ready = ctrl.load_req;

   pst_rom u_rom (
      .step (step),
      .ctrl (ctrl)
   );

   pst_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .ctrl      (ctrl),
      .flags     (flags),
      .step      (step)
   );

   pst_datapath #(
      .MAX_LIMIT  (MAX_LIMIT),
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .flags         (flags),
      .csr_write     (csr_write),
      .csr_max_value (csr_max_value),
      .req_valid     (req_valid),
      .req_cmd       (req_cmd),
      .req_order     (req_order),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status)
   );

endmodule

// ===== bench/tb_prime_sieve_table.sv =====
// ----------------------------------------------------------------------------
// tb_prime_sieve_table
// Self-checking bench for the prime sieve table. A directed table covers the
// query before any sieve, limits of 0, 1, 2, 3, 30, 1024, 1025 and 2047, the
// first and last primes and out-of-range orders. Random phases then set a
// limit, sieve and query with mostly valid orders. A local sieve predicts
// every result that the table does not give, and both handshakes stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_prime_sieve_table;
   import pst_pkg::*;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
   } answer_type;

   typedef enum logic [1:0] {
      ROW_CONFIG = 2'd0,
      ROW_SIEVE  = 2'd1,
      ROW_QUERY  = 2'd2
   } row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [VALUE_W-1:0]  arg;
      logic                typed;
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
   } plan_row_type;

   localparam int PLAN_ROWS = 31;
   localparam plan_row_type DIRECTED_PLAN [0:PLAN_ROWS-1] = '{
      '{ROW_QUERY,  11'd1,    1'b1, 11'd0,    ST_NO_SIEVE},
      '{ROW_QUERY,  11'd0,    1'b1, 11'd0,    ST_NO_SIEVE},
      '{ROW_QUERY,  11'd255,  1'b1, 11'd0,    ST_NO_SIEVE},
      '{ROW_SIEVE,  11'd0,    1'b1, 11'd1,    ST_OK},
      '{ROW_QUERY,  11'd1,    1'b1, 11'd2,    ST_OK},
      '{ROW_QUERY,  11'd2,    1'b1, 11'd0,    ST_RANGE},
      '{ROW_QUERY,  11'd0,    1'b1, 11'd0,    ST_RANGE},
      '{ROW_CONFIG, 11'd0,    1'b0, 11'd0,    ST_OK},
      '{ROW_SIEVE,  11'd255,  1'b1, 11'd0,    ST_OK},
      '{ROW_QUERY,  11'd1,    1'b1, 11'd0,    ST_RANGE},
      '{ROW_CONFIG, 11'd1,    1'b0, 11'd0,    ST_OK},
      '{ROW_SIEVE,  11'd0,    1'b1, 11'd0,    ST_OK},
      '{ROW_CONFIG, 11'd3,    1'b0, 11'd0,    ST_OK},
      '{ROW_SIEVE,  11'd170,  1'b1, 11'd2,    ST_OK},
      '{ROW_QUERY,  11'd2,    1'b1, 11'd3,    ST_OK},
      '{ROW_CONFIG, 11'd1024, 1'b0, 11'd0,    ST_OK},
      '{ROW_SIEVE,  11'd85,   1'b1, 11'd172,  ST_OK},
      '{ROW_QUERY,  11'd172,  1'b1, 11'd1021, ST_OK},
      '{ROW_QUERY,  11'd173,  1'b1, 11'd0,    ST_RANGE},
      '{ROW_QUERY,  11'd255,  1'b1, 11'd0,    ST_RANGE},
      '{ROW_QUERY,  11'd100,  1'b0, 11'd0,    ST_OK},
      '{ROW_CONFIG, 11'd2047, 1'b0, 11'd0,    ST_OK},
      '{ROW_SIEVE,  11'd0,    1'b1, 11'd172,  ST_OK},
      '{ROW_QUERY,  11'd172,  1'b1, 11'd1021, ST_OK},
      '{ROW_CONFIG, 11'd1025, 1'b0, 11'd0,    ST_OK},
      '{ROW_SIEVE,  11'd0,    1'b1, 11'd172,  ST_OK},
      '{ROW_QUERY,  11'd1,    1'b1, 11'd2,    ST_OK},
      '{ROW_CONFIG, 11'd30,   1'b0, 11'd0,    ST_OK},
      '{ROW_SIEVE,  11'd0,    1'b1, 11'd10,   ST_OK},
      '{ROW_QUERY,  11'd10,   1'b1, 11'd29,   ST_OK},
      '{ROW_QUERY,  11'd11,   1'b1, 11'd0,    ST_RANGE}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_cmd;
   logic [ORDER_W-1:0]  req_order;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [VALUE_W-1:0]  rsp_value;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_write;
   logic [VALUE_W-1:0]  csr_max_value;

   // predictor state
   logic [VALUE_W-1:0]  limit_reg;
   bit                  composite [0:MAX_LIMIT_DEFAULT];
   logic [VALUE_W-1:0]  prime_table [0:LIST_DEPTH_DEFAULT-1];
   logic [COUNT_W-1:0]  prime_total;
   bit                  sieve_seen;

   answer_type          pending_answers [$];
   bit                  idle_on;
   int                  mismatch_count;
   int                  sieve_items;
   int                  query_items;
   int                  checked_results;

   prime_sieve_table DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_order     (req_order),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status),
      .csr_write     (csr_write),
      .csr_max_value (csr_max_value)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   task automatic run_sieve_model(output logic [VALUE_W-1:0] count);
      int n;
      int i;
      int j;
      int found;
      n = (limit_reg > MAX_LIMIT_DEFAULT) ? MAX_LIMIT_DEFAULT : int'(limit_reg);
      for (i = 0; i <= MAX_LIMIT_DEFAULT; i++) composite[i] = 1'b0;
      composite[0] = 1'b1;
      composite[1] = 1'b1;
      for (i = 2; i * i <= n; i++) begin
         if (!composite[i]) begin
            for (j = i * i; j <= n; j += i) composite[j] = 1'b1;
         end
      end
      found = 0;
      for (i = 2; i <= n; i++) begin
         if (!composite[i] && found < LIST_DEPTH_DEFAULT) begin
            prime_table[found] = VALUE_W'(i);
            found++;
         end
      end
      prime_total = COUNT_W'(found);
      sieve_seen = 1'b1;
      count = VALUE_W'(found);
   endtask

   task automatic predict_answer(input logic cmd, input logic [ORDER_W-1:0] order,
                                 output answer_type answer);
      answer.value = '0;
      answer.status = ST_OK;
      if (cmd == CMD_SIEVE) begin
         run_sieve_model(answer.value);
      end else if (!sieve_seen) begin
         answer.status = ST_NO_SIEVE;
      end else if (order == 0 || order > prime_total || order > LIST_DEPTH_DEFAULT) begin
         answer.status = ST_RANGE;
      end else begin
         answer.value = prime_table[order - 1];
      end
   endtask

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input logic cmd, input logic [ORDER_W-1:0] order,
                            input bit typed, input answer_type typed_answer);
      int gap;
      answer_type answer;
      gap = idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_order <= order;
      do @(posedge clock); while (!req_ready);
      predict_answer(cmd, order, answer);
      pending_answers.push_back(typed ? typed_answer : answer);
      if (cmd == CMD_SIEVE) sieve_items++;
      else query_items++;
      @(negedge clock);
   endtask

   // hold off until every result is back, then write the limit
   task automatic write_limit(input logic [VALUE_W-1:0] limit);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_max_value <= limit;
      csr_write <= 1'b1;
      @(negedge clock);
      csr_write <= 1'b0;
      limit_reg = limit;
   endtask

   task automatic send_query(input logic [ORDER_W-1:0] order);
      send_item(CMD_QUERY, order, 1'b0, '0);
   endtask

   initial begin
      int gap;
      answer_type want;
      rsp_ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         gap = idle_on ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         checked_results++;
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: value %0d status %0d", rsp_value, rsp_status);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_value !== want.value || rsp_status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                           want.value, want.status, rsp_value, rsp_status);
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      #60_000_000;
      $display("tb_prime_sieve_table: done, errors");
      $finish;
   end

   initial begin
      plan_row_type row;
      answer_type typed_answer;
      logic [VALUE_W-1:0] limit;
      int pick;
      int phase;
      int k;

      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_SIEVE;
      req_order = '0;
      csr_write = 1'b0;
      csr_max_value = '0;
      idle_on = 1'b1;
      limit_reg = MAX_VALUE_RESET;
      prime_total = '0;
      sieve_seen = 1'b0;
      mismatch_count = 0;
      sieve_items = 0;
      query_items = 0;
      checked_results = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < PLAN_ROWS; r++) begin
         row = DIRECTED_PLAN[r];
         typed_answer.value = row.value;
         typed_answer.status = row.status;
         case (row.kind)
            ROW_CONFIG: write_limit(row.arg);
            ROW_SIEVE: send_item(CMD_SIEVE, ORDER_W'(row.arg), row.typed, typed_answer);
            default: send_item(CMD_QUERY, ORDER_W'(row.arg), row.typed, typed_answer);
         endcase
      end

      for (phase = 0; phase < 10; phase++) begin
         idle_on = (phase % 3) != 2;
         pick = $urandom_range(0, 9);
         if (pick == 0) limit = VALUE_W'($urandom_range(1024, 2047));
         else if (pick == 1) limit = VALUE_W'($urandom_range(0, 1));
         else limit = VALUE_W'($urandom_range(2, 200));
         write_limit(limit);
         send_item(CMD_SIEVE, ORDER_W'($urandom_range(0, 255)), 1'b0, '0);
         for (k = 0; k < 11; k++) begin
            pick = $urandom_range(0, 15);
            if (pick < 2)
               send_item(CMD_SIEVE, ORDER_W'($urandom_range(0, 255)), 1'b0, '0);
            else if (pick < 4 || prime_total == 0)
               send_query(ORDER_W'($urandom_range(0, 255)));
            else if (pick == 4)
               send_query('0);
            else
               send_query(ORDER_W'($urandom_range(1, int'(prime_total))));
         end
      end
      req_valid <= 1'b0;
      idle_on = 1'b1;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      $display("covered %0d sieve items and %0d query items, %0d results checked",
               sieve_items, query_items, checked_results);
      $display("limits from 0 to 2047, orders from 0 to 255, %0d mismatches", mismatch_count);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("tb_prime_sieve_table: done, clean");
      end else begin
         $display("tb_prime_sieve_table: done, errors");
      end
      $finish;
   end

endmodule
